// File: sv/buddy_block_allocator_unit_defines.svh
// assertion macros for the buddy allocator checker
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger, outside reset
`define BBA_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("buddy allocator check failed");

// condition holds in the cycle after the trigger, outside reset
`define BBA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("buddy allocator check failed");

// condition holds in the cycle after the trigger, reset included
`define BBA_ASSERT_NEXT_ANY(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) (trig) |=> (cond)) \
    else $error("buddy allocator check failed");

`endif

// File: sv/bba_pkg.sv
// shared types, constants and helpers of the buddy allocator
package bba_pkg;
  localparam int MAX_ARENA_LOG2 = 16;
  localparam int HEADER_BYTES   = 16;
  localparam int GRAN_LOG2      = (HEADER_BYTES >= 64) ? 7 : (HEADER_BYTES >= 32) ? 6 :
                                  (HEADER_BYTES >= 16) ? 5 : (HEADER_BYTES >= 8) ? 4 : 3;
  localparam int TBL_AW         = MAX_ARENA_LOG2 - GRAN_LOG2;
  localparam int TBL_DEPTH      = 1 << TBL_AW;
  localparam int MIN_ARENA_LOG2 = 5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_FIT    = 2'd1;
  localparam status_t ST_ZERO      = 2'd2;
  localparam status_t ST_NOT_ALLOC = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [5:0] entry_t;

  // block of 2^lg bytes holds need bytes
  function automatic logic fits(input logic [4:0] lg, input logic [16:0] need);
    logic [17:0] sz;
    sz = 18'd1 << lg;
    return (lg >= 5'd17) || (sz >= {1'b0, need});
  endfunction
endpackage

// File: sv/bba_in_if.sv
// request channel
interface bba_in_if import bba_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_bytes;
  logic [15:0] free_address;
  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink (input valid, mode, request_bytes, free_address, output ready);
endinterface

// File: sv/bba_out_if.sv
// result channel
interface bba_out_if import bba_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] payload_address;
  logic [16:0] block_bytes;
  modport source (output valid, status, payload_address, block_bytes, input ready);
  modport sink (input valid, status, payload_address, block_bytes, output ready);
endinterface

// File: sv/bba_cfg_if.sv
// configuration write channel
interface bba_cfg_if ();
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/buddy_block_allocator_unit.sv
// Buddy allocator over a 2^arena_log2 byte arena kept in a 2048-entry granule table (one
// 6-bit entry per 32-byte granule) in a single-port RAM with registered read. An allocate
// walks the table block by block, then halves the chosen block while a half still fits; a
// free checks the block and then merges it with its buddy while the buddy is free and of
// the same size. After reset and after every write of arena_log2 a clearing pass rewrites
// all 2048 table entries, and no request is taken meanwhile. A finished result sits in an
// output register, so the next request is taken while it waits.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_F_RD  = 4'd5;
  localparam logic [3:0] S_F_EV  = 4'd6;
  localparam logic [3:0] S_M_RD  = 4'd7;
  localparam logic [3:0] S_M_EV  = 4'd8;
  localparam logic [3:0] S_M_WLO = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  entry_t mem [TBL_DEPTH];
  entry_t rd_r;
  logic [TBL_AW-1:0] mem_addr;
  logic              mem_we;
  entry_t            mem_wd;

  logic [3:0]        state_r, state_nxt;
  logic [4:0]        al_r, al_nxt;
  logic [TBL_AW-1:0] clr_r, clr_nxt;
  logic [TBL_AW:0]   g_r, g_nxt;
  logic [TBL_AW-1:0] best_r, best_nxt;
  logic [4:0]        lg_r, lg_nxt;
  logic              found_r, found_nxt;
  logic [16:0]       need_r, need_nxt;
  status_t           rs_r, rs_nxt;
  logic [15:0]       ra_r, ra_nxt;
  logic [16:0]       rb_r, rb_nxt;
  logic              ov_r, ov_nxt;
  status_t           os_r, os_nxt;
  logic [15:0]       oa_r, oa_nxt;
  logic [16:0]       ob_r, ob_nxt;

  logic [TBL_AW:0]   cnt;
  logic [4:0]        cfg_lg;
  logic [4:0]        e_lg;
  logic [TBL_AW:0]   step;
  logic [15:0]       fstart;
  logic [TBL_AW-1:0] span;
  logic [4:0]        lg_dn;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  assign cnt    = (TBL_AW+1)'(1) << (al_r - 5'(GRAN_LOG2));
  assign cfg_lg = (cfg_ch.data < 5'(MIN_ARENA_LOG2)) ? 5'(MIN_ARENA_LOG2) :
                  (cfg_ch.data > 5'(MAX_ARENA_LOG2)) ? 5'(MAX_ARENA_LOG2) : cfg_ch.data;
  assign e_lg   = rd_r[4:0];
  assign step   = (e_lg >= 5'(GRAN_LOG2)) ? ((TBL_AW+1)'(1) << (e_lg - 5'(GRAN_LOG2)))
                                          : (TBL_AW+1)'(1);
  assign fstart = in_ch.free_address - 16'(HEADER_BYTES);
  assign span   = TBL_AW'(1) << (lg_r - 5'(GRAN_LOG2));
  assign lg_dn  = lg_r - 5'd1;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = ov_r;
  assign out_ch.status   = os_r;
  assign out_ch.payload_address = oa_r;
  assign out_ch.block_bytes     = ob_r;

  always_comb begin
    state_nxt = state_r; al_nxt = al_r; clr_nxt = clr_r; g_nxt = g_r;
    best_nxt = best_r; lg_nxt = lg_r; found_nxt = found_r; need_nxt = need_r;
    rs_nxt = rs_r; ra_nxt = ra_r; rb_nxt = rb_r;
    ov_nxt = ov_r; os_nxt = os_r; oa_nxt = oa_r; ob_nxt = ob_r;
    mem_addr = g_r[TBL_AW-1:0]; mem_we = 1'b0; mem_wd = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_addr = clr_r;
        mem_we   = 1'b1;
        mem_wd   = (clr_r == '0) ? {1'b0, al_r} : '0;
        clr_nxt  = clr_r + TBL_AW'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          rs_nxt = ST_NOT_ALLOC; ra_nxt = '0; rb_nxt = '0;
          if (in_ch.mode == MODE_ALLOC) begin
            need_nxt  = {1'b0, in_ch.request_bytes} + 17'(HEADER_BYTES);
            g_nxt     = '0;
            found_nxt = 1'b0;
            if (in_ch.request_bytes == '0) begin
              rs_nxt = ST_ZERO; state_nxt = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end else begin
            g_nxt = {1'b0, fstart[15:GRAN_LOG2]};
            if (in_ch.free_address < 16'(HEADER_BYTES) || fstart[GRAN_LOG2-1:0] != '0 ||
                {1'b0, fstart[15:GRAN_LOG2]} >= cnt) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_F_RD;
            end
          end
        end
      end
      S_A_RD: begin
        if (g_r >= cnt) begin
          if (found_r) begin
            state_nxt = S_SPLIT;
          end else begin
            rs_nxt = ST_NO_FIT; state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        state_nxt = S_A_RD;
        if (e_lg == '0) begin
          g_nxt = g_r + (TBL_AW+1)'(1);
        end else begin
          if (!rd_r[5] && fits(e_lg, need_r) && (!found_r || e_lg < lg_r)) begin
            found_nxt = 1'b1; best_nxt = g_r[TBL_AW-1:0]; lg_nxt = e_lg;
          end
          g_nxt = g_r + step;
        end
      end
      S_SPLIT: begin
        // lg_r holds the chosen block size here
        if (lg_r > 5'(GRAN_LOG2) && fits(lg_dn, need_r)) begin
          lg_nxt   = lg_dn;
          mem_addr = best_r + (TBL_AW'(1) << (lg_dn - 5'(GRAN_LOG2)));
          mem_we   = 1'b1;
          mem_wd   = {1'b0, lg_dn};
        end else begin
          mem_addr  = best_r;
          mem_we    = 1'b1;
          mem_wd    = {1'b1, lg_r};
          rs_nxt    = ST_OK;
          ra_nxt    = {best_r, GRAN_LOG2'(0)} + 16'(HEADER_BYTES);
          rb_nxt    = 17'd1 << lg_r;
          state_nxt = S_FIN;
        end
      end
      S_F_RD: state_nxt = S_F_EV;
      S_F_EV: begin
        if (e_lg == '0 || !rd_r[5] || e_lg < 5'(GRAN_LOG2)) begin
          state_nxt = S_FIN;
        end else begin
          rs_nxt = ST_OK; rb_nxt = 17'd1 << e_lg;
          mem_we = 1'b1; mem_wd = {1'b0, e_lg};
          lg_nxt = e_lg;
          state_nxt = S_M_RD;
        end
      end
      S_M_RD: begin
        if (lg_r < al_r) begin
          mem_addr  = g_r[TBL_AW-1:0] ^ span;
          state_nxt = S_M_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_M_EV: begin
        if (rd_r == {1'b0, lg_r}) begin
          // upper half of the pair stops beginning a block
          mem_addr  = g_r[TBL_AW-1:0] | span;
          mem_we    = 1'b1;
          mem_wd    = '0;
          state_nxt = S_M_WLO;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_M_WLO: begin
        mem_addr  = g_r[TBL_AW-1:0] & ~span;
        mem_we    = 1'b1;
        mem_wd    = {1'b0, lg_r + 5'd1};
        g_nxt     = {1'b0, g_r[TBL_AW-1:0] & ~span};
        lg_nxt    = lg_r + 5'd1;
        state_nxt = S_M_RD;
      end
      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1; os_nxt = rs_r; oa_nxt = ra_r; ob_nxt = rb_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_ch.valid) begin
      al_nxt = cfg_lg; clr_nxt = '0; state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      al_r    <= 5'(MAX_ARENA_LOG2);
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      al_r    <= al_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    g_r <= g_nxt; best_r <= best_nxt; lg_r <= lg_nxt; found_r <= found_nxt;
    need_r <= need_nxt; rs_r <= rs_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt;
    os_r <= os_nxt; oa_r <= oa_nxt; ob_r <= ob_nxt;
  end
endmodule

// File: sv/bba_checker.sv
// port-level checks of the buddy allocator and their bind
`include "buddy_block_allocator_unit_defines.svh"
module bba_checker import bba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input status_t     out_status,
  input logic [15:0] out_payload_address,
  input logic [16:0] out_block_bytes
);
  `BBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BBA_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, !in_ready)
  `BBA_ASSERT_NEXT_ANY(a_reset_clears, !rst_n, !in_ready)
  `BBA_ASSERT_SAME(a_err_zero, out_valid && out_status != ST_OK, out_payload_address == '0 && out_block_bytes == '0)
  `BBA_ASSERT_SAME(a_ok_size, out_valid && out_status == ST_OK, $onehot(out_block_bytes))
endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_payload_address(out_ch.payload_address), .out_block_bytes(out_ch.block_bytes)
);

// File: sim/tb.sv
// testbench for the buddy block allocator: directed and random requests checked against a model
`timescale 1ns / 1ps
module tb;
  import bba_pkg::*;

  logic clk;
  logic rst_n;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();
  bba_cfg_if cfg_ch ();

  buddy_block_allocator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  typedef struct packed {
    status_t     status;
    logic [15:0] payload_address;
    logic [16:0] block_bytes;
  } outcome_t;

  // model copy of the granule table and arena size
  entry_t     gran_tbl [TBL_DEPTH];
  int         arena_lg;
  outcome_t   pending_outcomes [$];
  int         errors;
  int         n_sent;
  int         n_checked;
  int         n_ok_alloc;
  int         n_ok_free;
  bit         calm;
  int unsigned live_addrs [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gran_count();
    return (arena_lg >= GRAN_LOG2) ? (1 << (arena_lg - GRAN_LOG2)) : 1;
  endfunction

  function automatic void model_init(input logic [4:0] v);
    int lg;
    lg = v;
    if (lg < MIN_ARENA_LOG2) lg = MIN_ARENA_LOG2;
    if (lg > MAX_ARENA_LOG2) lg = MAX_ARENA_LOG2;
    arena_lg = lg;
    foreach (gran_tbl[i]) gran_tbl[i] = '0;
    gran_tbl[0] = entry_t'(lg);
  endfunction

  function automatic outcome_t predict_alloc(input int unsigned n);
    outcome_t r;
    int unsigned g, best, best_lg, lg, need, cnt;
    bit found;
    r = '0;
    need = n + HEADER_BYTES;
    cnt = gran_count();
    found = 0; best = 0; best_lg = 0; g = 0;
    if (n == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    while (g < cnt) begin
      lg = gran_tbl[g][4:0];
      if (lg == 0) begin
        g++;
        continue;
      end
      if (!gran_tbl[g][5] && (1 << lg) >= need && (!found || lg < best_lg)) begin
        found = 1; best = g; best_lg = lg;
      end
      g += (lg >= GRAN_LOG2) ? (1 << (lg - GRAN_LOG2)) : 1;
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end
    while (best_lg > GRAN_LOG2 && (1 << (best_lg - 1)) >= need) begin
      best_lg--;
      gran_tbl[(best + (1 << (best_lg - GRAN_LOG2))) % TBL_DEPTH] = entry_t'(best_lg);
    end
    gran_tbl[best] = entry_t'(best_lg | 32);
    r.status = ST_OK;
    r.payload_address = 16'((best << GRAN_LOG2) + HEADER_BYTES);
    r.block_bytes = 17'(1 << best_lg);
    return r;
  endfunction

  function automatic outcome_t predict_free(input int unsigned addr);
    outcome_t r;
    int unsigned st, g, lg, span, b;
    r = '0;
    r.status = ST_NOT_ALLOC;
    if (addr < HEADER_BYTES) return r;
    st = addr - HEADER_BYTES;
    if ((st & ((1 << GRAN_LOG2) - 1)) != 0) return r;
    g = st >> GRAN_LOG2;
    if (g >= gran_count() || g >= TBL_DEPTH) return r;
    lg = gran_tbl[g][4:0];
    if (lg == 0 || !gran_tbl[g][5] || lg < GRAN_LOG2) return r;
    r.status = ST_OK;
    r.block_bytes = 17'(1 << lg);
    gran_tbl[g] = entry_t'(lg);
    while (lg < arena_lg) begin
      span = 1 << (lg - GRAN_LOG2);
      b = g ^ span;
      if (b >= TBL_DEPTH || gran_tbl[b] != entry_t'(lg)) break;
      gran_tbl[g] = '0;
      gran_tbl[b] = '0;
      g &= ~span;
      lg++;
      gran_tbl[g] = entry_t'(lg);
    end
    return r;
  endfunction

  function automatic bit stall_now();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  task automatic send_request(input logic mode, input logic [15:0] nbytes,
                              input logic [15:0] addr);
    outcome_t r;
    while (stall_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.request_bytes <= nbytes;
    in_ch.free_address  <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (mode == MODE_FREE) r = predict_free(addr);
    else r = predict_alloc(nbytes);
    if (mode == MODE_ALLOC && r.status == ST_OK) begin
      live_addrs.push_back(r.payload_address);
      n_ok_alloc++;
    end
    if (mode == MODE_FREE && r.status == ST_OK) n_ok_free++;
    pending_outcomes.push_back(r);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_arena(input logic [4:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_init(v);
    live_addrs.delete();
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      out_ch.ready <= !stall_now();
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          n_checked++;
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
            errors++;
          end
          if (out_ch.payload_address !== want.payload_address) begin
            $display("%0t: payload_address expected %0h actual %0h", $time,
                     want.payload_address, out_ch.payload_address);
            errors++;
          end
          if (out_ch.block_bytes !== want.block_bytes) begin
            $display("%0t: block_bytes expected %0d actual %0d", $time,
                     want.block_bytes, out_ch.block_bytes);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_request(MODE_ALLOC, 16'd0, 16'hFFFF);
    send_request(MODE_ALLOC, 16'hFFFF, 16'd0);
    send_request(MODE_ALLOC, 16'd1, 16'd0);
    send_request(MODE_ALLOC, 16'd16, 16'd0);
    send_request(MODE_ALLOC, 16'd17, 16'd0);
    send_request(MODE_ALLOC, 16'd65520, 16'd0);
    send_request(MODE_FREE, 16'hFFFF, 16'd0);
    send_request(MODE_FREE, 16'd0, 16'd15);
    send_request(MODE_FREE, 16'd0, 16'd17);
    send_request(MODE_FREE, 16'd0, 16'd16);
    send_request(MODE_FREE, 16'd0, 16'd16);
    send_request(MODE_FREE, 16'd0, 16'd48);
    send_request(MODE_FREE, 16'd0, 16'hFFF0);
    send_request(MODE_FREE, 16'd0, 16'd80);
    send_request(MODE_ALLOC, 16'd65520, 16'd0);
    send_request(MODE_FREE, 16'd0, 16'd16);
    write_arena(5'd0);
    send_request(MODE_ALLOC, 16'd1, 16'd0);
    send_request(MODE_FREE, 16'd0, 16'd16);
    write_arena(5'd6);
    send_request(MODE_ALLOC, 16'd48, 16'd0);
    send_request(MODE_ALLOC, 16'd1, 16'd0);
    send_request(MODE_FREE, 16'd0, 16'd16);
    send_request(MODE_FREE, 16'd0, 16'd80);
    write_arena(5'd31);
    send_request(MODE_FREE, 16'd0, 16'hFFF0);
  endtask

  task automatic test_random(input int count);
    int k, idx;
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        // mostly small, sometimes huge
        v = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
        send_request(MODE_ALLOC, v, 16'($urandom));
      end else if (k < 85 && live_addrs.size() != 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        v = 16'(live_addrs[idx]);
        live_addrs.delete(idx);
        send_request(MODE_FREE, 16'($urandom), v);
      end else if (k < 92) begin
        send_request(MODE_FREE, 16'($urandom), 16'($urandom));
      end else begin
        send_request(MODE_ALLOC, 16'd0, 16'($urandom));
      end
    end
  endtask

  initial begin
    errors = 0; n_sent = 0; n_checked = 0; n_ok_alloc = 0; n_ok_free = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.free_address = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    model_init(5'd16);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_arena(5'd16);
    test_random(500);
    calm = 1'b1;
    test_random(200);
    calm = 1'b0;
    write_arena(5'd10);
    test_random(300);
    write_arena(5'd5);
    test_random(100);
    write_arena(5'd13);
    test_random(400);
    drain();
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("%0d allocations and %0d frees succeeded over arenas 2^5 to 2^16",
             n_ok_alloc, n_ok_free);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/bba_pkg.sv
sv/bba_in_if.sv
sv/bba_out_if.sv
sv/bba_cfg_if.sv
sv/buddy_block_allocator_unit.sv
sv/bba_checker.sv
sim/tb.sv
